>>> rtl/stup_pkg.sv
`timescale 1ns / 1ps

package stup_pkg;

    // Parse phase of the current string
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } stup_phase_t;

    // Narrow control state carried between the step logic and the state registers
    typedef struct packed {
        stup_phase_t phase;
        logic        negative;
        logic [5:0]  base;
    } stup_ctl_t;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // Radix values
    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    // Configuration register indexes
    localparam logic REG_NUMBER_BASE = 1'b0;

endpackage

>>> rtl/stup_step.sv
`timescale 1ns / 1ps

module stup_step #(
    parameter int OFFSET_BITS = 16
) (
    input  logic [7:0]              ch,
    input  logic                    first,
    input  logic [5:0]              cfg_base,
    input  stup_pkg::stup_ctl_t     ctl,
    input  logic [63:0]             acc,
    input  logic [OFFSET_BITS-1:0]  consumed,
    output stup_pkg::stup_ctl_t     ctl_next,
    output logic [63:0]             acc_next,
    output logic [OFFSET_BITS-1:0]  consumed_next,
    output logic                    emit,
    output logic [63:0]             value,
    output logic [OFFSET_BITS-1:0]  end_offset
);
    import stup_pkg::*;

    localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

    stup_ctl_t              cur_ctl;
    logic [63:0]            cur_acc;
    logic [OFFSET_BITS-1:0] cur_cnt;
    logic [OFFSET_BITS-1:0] cnt_inc;
    logic                   is_digit;
    logic [5:0]             dig_val;
    logic                   do_digit;
    logic [5:0]             eff_base;
    logic [63:0]            product;

    // Restart on a first-flagged word
    always_comb
    begin
        if (first)
        begin
            cur_ctl.phase    = PH_LEAD;
            cur_ctl.negative = 1'b0;
            cur_ctl.base     = cfg_base;
            cur_acc          = 64'd0;
            cur_cnt          = '0;
        end
        else
        begin
            cur_ctl = ctl;
            cur_acc = acc;
            cur_cnt = consumed;
        end
    end

    // Saturating count of consumed characters
    assign cnt_inc = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + OFFSET_BITS'(1);

    // Decode the digit value, letters from ten up
    always_comb
    begin
        is_digit = 1'b1;
        dig_val  = 6'd0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            dig_val = 6'(ch - CH_0);
        end
        else if (ch >= CH_LA && ch <= CH_LZ)
        begin
            dig_val = 6'(ch - CH_LA) + 6'd10;
        end
        else if (ch >= CH_UA && ch <= CH_UZ)
        begin
            dig_val = 6'(ch - CH_UA) + 6'd10;
        end
        else
        begin
            is_digit = 1'b0;
        end
    end

    // Walk the phase and pick whether this word is a digit step
    always_comb
    begin
        ctl_next      = cur_ctl;
        consumed_next = cur_cnt;
        do_digit      = 1'b0;
        eff_base      = cur_ctl.base;
        unique case (cur_ctl.phase)
            PH_LEAD, PH_PREFIX:
            begin
                if (cur_ctl.phase == PH_LEAD &&
                    (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF))
                begin
                    consumed_next = cnt_inc;
                end
                else if (cur_ctl.phase == PH_LEAD && (ch == CH_PLUS || ch == CH_MINUS))
                begin
                    ctl_next.negative = (ch == CH_MINUS);
                    ctl_next.phase    = PH_PREFIX;
                    consumed_next     = cnt_inc;
                end
                else if (cur_ctl.base == BASE_AUTO)
                begin
                    if (ch == CH_0)
                    begin
                        ctl_next.base  = BASE_OCT;
                        ctl_next.phase = PH_ZERO;
                        consumed_next  = cnt_inc;
                    end
                    else
                    begin
                        ctl_next.base = BASE_DEC;
                        eff_base      = BASE_DEC;
                        do_digit      = 1'b1;
                    end
                end
                else if (cur_ctl.base == BASE_HEX && ch == CH_0)
                begin
                    ctl_next.phase = PH_ZERO;
                    consumed_next  = cnt_inc;
                end
                else
                begin
                    do_digit = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (ch == CH_LX || ch == CH_UX)
                begin
                    ctl_next.base  = BASE_HEX;
                    ctl_next.phase = PH_DIGITS;
                    consumed_next  = cnt_inc;
                end
                else
                begin
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                do_digit = 1'b1;
            end
            default:
            begin
                ctl_next = cur_ctl;
            end
        endcase

        // Take the digit, or stop and report
        emit     = 1'b0;
        acc_next = cur_acc;
        if (do_digit)
        begin
            if (is_digit && dig_val < eff_base)
            begin
                acc_next       = product;
                consumed_next  = cnt_inc;
                ctl_next.phase = PH_DIGITS;
            end
            else
            begin
                emit           = 1'b1;
                ctl_next.phase = PH_DONE;
            end
        end
    end

    // Multiply-accumulate by the radix, wrapping at 64 bits
    assign product = cur_acc * 64'(eff_base) + 64'(dig_val);

    // Result payload
    assign value      = cur_ctl.negative ? (64'd0 - cur_acc) : cur_acc;
    assign end_offset = cur_cnt;

endmodule

>>> rtl/string_to_unsigned_parser.sv
`timescale 1ns / 1ps

// Streaming unsigned-integer parser. One character enters per word on the
// s_ side; a word with tuser set starts a new string. Leading space, tab and
// newline are skipped, one sign is taken, then digits in the radix latched
// from number_base at the start of the string (0 auto-detects 0x hex, 0
// octal, else decimal; 16 also skips 0x). At the first non-digit one result
// word carries the value (mod 2^64, negated for '-') and the count of
// characters consumed, saturating. The block takes one character per cycle
// unless a full result register that is not taken stalls the input; the
// stopping character passes the input register and the 64-bit by 6-bit
// multiply-accumulate digit step before the result register presents it.
module string_to_unsigned_parser #(
    parameter int OFFSET_BITS = 16,
    parameter int TDATA_W     = ((64 + OFFSET_BITS + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // Input characters
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] ch
    input  logic               s_tuser,   // [0] first
    // Results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [63:0] value, then end_offset
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import stup_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             ch_reg;
    logic                   first_reg;
    logic                   advance;

    logic [5:0]             number_base_reg;
    stup_ctl_t              ctl_reg;
    logic [63:0]            acc_reg;
    logic [OFFSET_BITS-1:0] consumed_reg;

    stup_ctl_t              ctl_next;
    logic [63:0]            acc_next;
    logic [OFFSET_BITS-1:0] consumed_next;
    logic                   emit;
    logic [63:0]            value_next;
    logic [OFFSET_BITS-1:0] end_offset_next;

    logic                   out_valid_reg;
    logic [63:0]            value_reg;
    logic [OFFSET_BITS-1:0] end_offset_reg;

    // Pipeline control: step when the result register can take a word
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUMBER_BASE) ? {26'd0, number_base_reg} : 32'd0;

    stup_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .ch            (ch_reg),
        .first         (first_reg),
        .cfg_base      (number_base_reg),
        .ctl           (ctl_reg),
        .acc           (acc_reg),
        .consumed      (consumed_reg),
        .ctl_next      (ctl_next),
        .acc_next      (acc_next),
        .consumed_next (consumed_next),
        .emit          (emit),
        .value         (value_next),
        .end_offset    (end_offset_next)
    );

    // Hold configuration, control state, input valid and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg  <= BASE_AUTO;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            ctl_reg.phase    <= PH_IDLE;
            ctl_reg.negative <= 1'b0;
            ctl_reg.base     <= BASE_AUTO;
            acc_reg          <= 64'd0;
            consumed_reg     <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == REG_NUMBER_BASE)
            begin
                number_base_reg <= pwdata[5:0];
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                ctl_reg      <= ctl_next;
                acc_reg      <= acc_next;
                consumed_reg <= consumed_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture input and result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ch_reg    <= s_tdata;
            first_reg <= s_tuser;
        end
        if (advance && emit)
        begin
            value_reg      <= value_next;
            end_offset_reg <= end_offset_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({end_offset_reg, value_reg});

`ifndef SYNTHESIS
    // An empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    // A new result comes only from a step of the parser
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance) && $past(emit))
        else $error("result appeared without a step");

    // Sign is only taken on leaving the lead phase
    a_lead_positive: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.phase == PH_LEAD |-> !ctl_reg.negative)
        else $error("sign set during lead phase");

    // After a leading zero the radix is octal or hex
    a_zero_base: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.phase == PH_ZERO |-> (ctl_reg.base == BASE_OCT || ctl_reg.base == BASE_HEX))
        else $error("bad radix after leading zero");

    // Digits only accumulate with a resolved radix
    a_digits_base: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.phase == PH_DIGITS |-> ctl_reg.base != BASE_AUTO)
        else $error("digits taken with auto radix");
`endif

endmodule
